FILE: rtl/core/urs_pkg.sv
// Shared types and constants of the ultrasonic range sequencer.
`timescale 1ns / 1ps
package urs_pkg;

	// Sequencer phase codes
	localparam logic [2:0] PH_TRIG_LOW  = 3'd0;
	localparam logic [2:0] PH_TRIG_HIGH = 3'd1;
	localparam logic [2:0] PH_WAIT      = 3'd2;
	localparam logic [2:0] PH_MEASURE   = 3'd3;
	localparam logic [2:0] PH_PAUSE     = 3'd4;

	// Register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_CM   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_CM    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE      = 3'd6;

	// Distance codes
	localparam logic [9:0] NO_ECHO_CM = 10'd999;
	localparam logic [9:0] MAX_CM     = 10'd998;

	typedef struct packed {
		logic [7:0]  trigger_low_ticks;
		logic [7:0]  trigger_high_ticks;
		logic [19:0] echo_wait_limit;
		logic [15:0] echo_max_ticks;
		logic [7:0]  ticks_per_cm;
		logic [9:0]  near_threshold_cm;
		logic [19:0] pause_ticks;
	} urs_cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [19:0] phase_count;
		logic [16:0] echo_count;
		logic [7:0]  cm_subcount;
		logic [9:0]  cm_count;
		logic [9:0]  last_distance;
		logic        led_state;
		logic        timed_out;
	} urs_state_t;

	typedef struct packed {
		logic       trigger_level;
		logic       led_on;
		logic [9:0] distance_cm;
		logic       distance_ready;
		logic       no_echo;
	} urs_result_t;

	// A zero length counts as one
	function automatic logic [7:0] at_least_one(input logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

endpackage

FILE: rtl/core/urs_if.sv
// Handshake interfaces of the ultrasonic range sequencer channels.
`timescale 1ns / 1ps

interface urs_echo_if;
	logic valid;
	logic ready;
	logic echo_level;
	modport source (output valid, output echo_level, input ready);
	modport sink (input valid, input echo_level, output ready);
endinterface

interface urs_result_if;
	logic       valid;
	logic       ready;
	logic       trigger_level;
	logic       led_on;
	logic [9:0] distance_cm;
	logic       distance_ready;
	logic       no_echo;
	modport source (output valid, output trigger_level, output led_on, output distance_cm,
		output distance_ready, output no_echo, input ready);
	modport sink (input valid, input trigger_level, input led_on, input distance_cm,
		input distance_ready, input no_echo, output ready);
endinterface

interface urs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [19:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/urs_step.sv
// Next-state and result logic for one tick of the range sequencer.
`timescale 1ns / 1ps
module urs_step
	import urs_pkg::*;
(
	input  urs_cfg_t    cfg,
	input  urs_state_t  st,
	input  logic        echo_level,
	output urs_state_t  nxt,
	output urs_result_t res
);

	logic [19:0] pc_inc;
	logic [16:0] ec_inc;
	logic [7:0]  sub_inc;
	logic [9:0]  cm_tmp;
	logic [19:0] low_pc;
	logic        trig;
	logic        rdy;
	logic        fin;
	logic [9:0]  fin_dist;
	logic        fin_to;

	always_comb begin
		nxt = st;
		trig = 1'b0;
		rdy = 1'b0;
		fin = 1'b0;
		fin_dist = '0;
		fin_to = 1'b0;
		pc_inc = st.phase_count + 20'd1;
		ec_inc = st.echo_count + 17'd1;
		sub_inc = st.cm_subcount + 8'd1;
		cm_tmp = st.cm_count;
		low_pc = '0;
		unique case (st.phase)
			PH_TRIG_HIGH: begin
				trig = 1'b1;
				nxt.phase_count = pc_inc;
				if (pc_inc >= {12'd0, at_least_one(cfg.trigger_high_ticks)}) begin
					nxt.phase = PH_WAIT;
					nxt.phase_count = '0;
				end
			end
			PH_WAIT: begin
				// Echo rise starts a measurement; a low tick past the limit times out
				if (echo_level) begin
					nxt.phase = PH_MEASURE;
					nxt.echo_count = '0;
					nxt.cm_subcount = '0;
					nxt.cm_count = '0;
				end else if (st.phase_count >= cfg.echo_wait_limit) begin
					fin = 1'b1;
					fin_dist = NO_ECHO_CM;
					fin_to = 1'b1;
				end else begin
					nxt.phase_count = pc_inc;
				end
			end
			PH_MEASURE: begin
				// Count ticks and cm, saturate the distance; echo fall or cap ends it
				nxt.echo_count = ec_inc;
				if (sub_inc >= at_least_one(cfg.ticks_per_cm)) begin
					nxt.cm_subcount = '0;
					if (st.cm_count < MAX_CM) begin
						cm_tmp = st.cm_count + 10'd1;
					end
				end else begin
					nxt.cm_subcount = sub_inc;
				end
				nxt.cm_count = cm_tmp;
				if (!echo_level || (ec_inc > {1'b0, cfg.echo_max_ticks})) begin
					fin = 1'b1;
					fin_dist = cm_tmp;
				end
			end
			PH_PAUSE: begin
				nxt.phase_count = pc_inc;
				if (pc_inc >= cfg.pause_ticks) begin
					nxt.phase = PH_TRIG_LOW;
					nxt.phase_count = '0;
				end
			end
			default: begin
				// Trigger low phase; stray codes restart it with one tick counted
				low_pc = (st.phase == PH_TRIG_LOW) ? pc_inc : 20'd1;
				nxt.phase = PH_TRIG_LOW;
				nxt.phase_count = low_pc;
				if (low_pc >= {12'd0, at_least_one(cfg.trigger_low_ticks)}) begin
					nxt.phase = PH_TRIG_HIGH;
					nxt.phase_count = '0;
				end
			end
		endcase

		// Report a finished measurement, then pause or, if none, trigger low
		if (fin) begin
			rdy = 1'b1;
			nxt.last_distance = fin_dist;
			nxt.led_state = (fin_dist != 10'd0) && (fin_dist < cfg.near_threshold_cm);
			nxt.timed_out = fin_to;
			nxt.phase_count = '0;
			nxt.phase = (cfg.pause_ticks == 20'd0) ? PH_TRIG_LOW : PH_PAUSE;
		end

		res.trigger_level = trig;
		res.led_on = nxt.led_state;
		res.distance_cm = nxt.last_distance;
		res.distance_ready = rdy;
		res.no_echo = nxt.timed_out;
	end

endmodule

FILE: rtl/core/ultrasonic_range_sequencer.sv
// Top level of the ultrasonic range sequencer: registers, state and output stage.
//
//  channel  modport  payload                                       request means
//  echo     sink     echo_level                                    one microsecond tick
//  result   source   trigger_level led_on distance_cm              result of one tick
//                    distance_ready no_echo
//  cfg      sink     index data                                    register write
//
// One tick is taken every cycle the output is not stalled; its result appears in
// the output register on the next cycle, after a single pass through the step logic.
// The output register holds a stalled result; a new tick is taken whenever that
// register is empty or being read in the same cycle.
// Reset clears the sequencer state and loads the register defaults.
// Configuration writes are always accepted and take effect on the next tick.
`timescale 1ns / 1ps
module ultrasonic_range_sequencer
	import urs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	urs_echo_if.sink      echo,
	urs_result_if.source  result,
	urs_cfg_if.sink       cfg
);

	urs_cfg_t    cfg_q;
	urs_state_t  state_q;
	urs_state_t  state_nxt;
	urs_result_t res_nxt;
	urs_result_t out_q;
	logic        out_valid_q;
	logic        take;

	assign cfg.ready = 1'b1;
	assign echo.ready = !out_valid_q || result.ready;
	assign take = echo.valid && echo.ready;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_low_ticks <= 8'd2;
			cfg_q.trigger_high_ticks <= 8'd10;
			cfg_q.echo_wait_limit <= 20'd1000000;
			cfg_q.echo_max_ticks <= 16'd50000;
			cfg_q.ticks_per_cm <= 8'd58;
			cfg_q.near_threshold_cm <= 10'd10;
			cfg_q.pause_ticks <= 20'd100000;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TRIG_LOW:   cfg_q.trigger_low_ticks <= cfg.data[7:0];
				REG_TRIG_HIGH:  cfg_q.trigger_high_ticks <= cfg.data[7:0];
				REG_WAIT_LIMIT: cfg_q.echo_wait_limit <= cfg.data;
				REG_ECHO_MAX:   cfg_q.echo_max_ticks <= cfg.data[15:0];
				REG_TICKS_CM:   cfg_q.ticks_per_cm <= cfg.data[7:0];
				REG_NEAR_CM:    cfg_q.near_threshold_cm <= cfg.data[9:0];
				REG_PAUSE:      cfg_q.pause_ticks <= cfg.data;
				default: ;
			endcase
		end
	end

	urs_step u_step (
		.cfg        (cfg_q),
		.st         (state_q),
		.echo_level (echo.echo_level),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Advance the sequencer on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_TRIG_LOW, default: '0};
			out_valid_q <= 1'b0;
		end else if (take) begin
			state_q <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res_nxt;
		end
	end

	assign result.valid = out_valid_q;
	assign result.trigger_level = out_q.trigger_level;
	assign result.led_on = out_q.led_on;
	assign result.distance_cm = out_q.distance_cm;
	assign result.distance_ready = out_q.distance_ready;
	assign result.no_echo = out_q.no_echo;

`ifndef SYNTHESIS
	a_no_echo_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.no_echo |-> out_q.distance_cm == NO_ECHO_CM)
		else $error("no-echo result without distance 999");
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.no_echo |-> out_q.distance_cm <= MAX_CM)
		else $error("measured distance above saturation");
	a_trig_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.trigger_level |-> !out_q.distance_ready)
		else $error("distance reported during trigger pulse");
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("accepted tick left no result");
`endif

endmodule

FILE: tb/ultrasonic_range_sequencer_tb.sv
// Self-checking testbench for the ultrasonic range sequencer tick stream.
`timescale 1ns / 1ps
module ultrasonic_range_sequencer_tb;
	import urs_pkg::*;

	// Write to the index past the last register; the block ignores it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam urs_cfg_t CFG_RESET = '{
		trigger_low_ticks:  8'd2,
		trigger_high_ticks: 8'd10,
		echo_wait_limit:    20'd1000000,
		echo_max_ticks:     16'd50000,
		ticks_per_cm:       8'd58,
		near_threshold_cm:  10'd10,
		pause_ticks:        20'd100000
	};

	// Pin patterns expected during the first measurement after reset
	localparam urs_result_t IDLE_PINS     = '{1'b0, 1'b0, 10'd0, 1'b0, 1'b0};
	localparam urs_result_t TRIG_PINS     = '{1'b1, 1'b0, 10'd0, 1'b0, 1'b0};
	localparam urs_result_t FIRST_READING = '{1'b0, 1'b0, 10'd0, 1'b1, 1'b0};

	typedef struct packed {
		logic        lvl;
		logic [3:0]  reps;
		logic        typed;
		urs_result_t want;
	} bringup_row_t;

	// First measurement with reset settings: low, pulse (echo ignored), wait,
	// rise and short echo, zero-distance reading, start of the pause
	bringup_row_t bringup_rows [6] = '{
		'{1'b0, 4'd2,  1'b1, IDLE_PINS},
		'{1'b1, 4'd10, 1'b1, TRIG_PINS},
		'{1'b0, 4'd3,  1'b1, IDLE_PINS},
		'{1'b1, 4'd6,  1'b1, IDLE_PINS},
		'{1'b0, 4'd1,  1'b1, FIRST_READING},
		'{1'b0, 4'd2,  1'b1, IDLE_PINS}
	};

	logic clk = 1'b0;
	logic arst_n;

	urs_echo_if   echo_ch ();
	urs_result_if res_ch ();
	urs_cfg_if    cfg_ch ();

	ultrasonic_range_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.echo   (echo_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #2 clk = ~clk;

	// Sequencer mirror and the pin results still owed by the block
	urs_cfg_t    sonar_cfg;
	urs_state_t  sonar;
	urs_result_t owed_pins [$];

	// Driver side hint: a hand-written expectation for the current request
	logic        stim_typed;
	urs_result_t stim_want;

	// Echo shaping plan for the next measurement
	int  rise_delay;
	int  echo_span;
	bit  silent_echo;
	bit  long_echo;
	bit  calm;
	int  fails = 0;

	// Close a measurement: latch distance, LED and time-out flag, go to pause (trigger low if pause is zero)
	task automatic close_reading(input logic [9:0] reading_cm, input logic timeout);
		sonar.last_distance = reading_cm;
		sonar.led_state = (reading_cm != 10'd0) &&
			(reading_cm < sonar_cfg.near_threshold_cm);
		sonar.timed_out = timeout;
		sonar.phase_count = '0;
		sonar.phase = (sonar_cfg.pause_ticks == 20'd0) ? PH_TRIG_LOW : PH_PAUSE;
	endtask

	// Advance the mirror by one tick and form the pins of that tick
	task automatic sequence_tick(input logic echo_in, output urs_result_t pins);
		logic trig;
		logic fresh;
		logic [19:0] low_len;
		logic [19:0] high_len;
		logic [7:0]  cm_len;
		trig = 1'b0;
		fresh = 1'b0;
		low_len = (sonar_cfg.trigger_low_ticks == 8'd0) ? 20'd1 :
			20'(sonar_cfg.trigger_low_ticks);
		high_len = (sonar_cfg.trigger_high_ticks == 8'd0) ? 20'd1 :
			20'(sonar_cfg.trigger_high_ticks);
		cm_len = (sonar_cfg.ticks_per_cm == 8'd0) ? 8'd1 : sonar_cfg.ticks_per_cm;
		case (sonar.phase)
			PH_TRIG_HIGH: begin
				trig = 1'b1;
				sonar.phase_count = sonar.phase_count + 20'd1;
				if (sonar.phase_count >= high_len) begin
					sonar.phase = PH_WAIT;
					sonar.phase_count = '0;
				end
			end
			PH_WAIT: begin
				if (echo_in) begin
					sonar.phase = PH_MEASURE;
					sonar.echo_count = '0;
					sonar.cm_subcount = '0;
					sonar.cm_count = '0;
				end else if (sonar.phase_count >= sonar_cfg.echo_wait_limit) begin
					close_reading(NO_ECHO_CM, 1'b1);
					fresh = 1'b1;
				end else begin
					sonar.phase_count = sonar.phase_count + 20'd1;
				end
			end
			PH_MEASURE: begin
				sonar.echo_count = sonar.echo_count + 17'd1;
				sonar.cm_subcount = sonar.cm_subcount + 8'd1;
				if (sonar.cm_subcount >= cm_len) begin
					sonar.cm_subcount = '0;
					if (sonar.cm_count < MAX_CM)
						sonar.cm_count = sonar.cm_count + 10'd1;
				end
				if (!echo_in || sonar.echo_count > 17'(sonar_cfg.echo_max_ticks)) begin
					close_reading(sonar.cm_count, 1'b0);
					fresh = 1'b1;
				end
			end
			PH_PAUSE: begin
				sonar.phase_count = sonar.phase_count + 20'd1;
				if (sonar.phase_count >= sonar_cfg.pause_ticks) begin
					sonar.phase = PH_TRIG_LOW;
					sonar.phase_count = '0;
				end
			end
			default: begin
				sonar.phase_count = (sonar.phase == PH_TRIG_LOW) ?
					sonar.phase_count + 20'd1 : 20'd1;
				sonar.phase = PH_TRIG_LOW;
				if (sonar.phase_count >= low_len) begin
					sonar.phase = PH_TRIG_HIGH;
					sonar.phase_count = '0;
				end
			end
		endcase
		pins = '{trig, sonar.led_state, sonar.last_distance, fresh, sonar.timed_out};
	endtask

	// Pick the echo level of the next tick from where the sequencer stands
	function automatic logic choose_echo();
		logic lvl;
		int cm_len;
		cm_len = (sonar_cfg.ticks_per_cm == 8'd0) ? 1 : int'(sonar_cfg.ticks_per_cm);
		case (sonar.phase)
			PH_WAIT: begin
				if (silent_echo) begin
					lvl = 1'b0;
				end else if (rise_delay == 0) begin
					lvl = 1'b1;
				end else begin
					rise_delay--;
					lvl = ($urandom_range(0, 49) == 0);
				end
			end
			PH_MEASURE: begin
				if (echo_span == 0) begin
					lvl = 1'b0;
				end else begin
					echo_span--;
					lvl = 1'b1;
				end
			end
			default: begin
				// Stray echo outside the listening window, and a fresh plan
				lvl = ($urandom_range(0, 15) == 0);
				silent_echo = (sonar_cfg.echo_wait_limit <= 20'd60) &&
					($urandom_range(0, 4) == 0);
				rise_delay = $urandom_range(0, 40);
				echo_span = long_echo ? $urandom_range(1000, 1005) :
					$urandom_range(0, 3 * cm_len + 4);
			end
		endcase
		return lvl;
	endfunction

	// Track config writes, predict accepted ticks, check returned pins
	always @(posedge clk) begin : watch_pins
		urs_result_t calc;
		urs_result_t got;
		urs_result_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_TRIG_LOW:   sonar_cfg.trigger_low_ticks = cfg_ch.data[7:0];
					REG_TRIG_HIGH:  sonar_cfg.trigger_high_ticks = cfg_ch.data[7:0];
					REG_WAIT_LIMIT: sonar_cfg.echo_wait_limit = cfg_ch.data;
					REG_ECHO_MAX:   sonar_cfg.echo_max_ticks = cfg_ch.data[15:0];
					REG_TICKS_CM:   sonar_cfg.ticks_per_cm = cfg_ch.data[7:0];
					REG_NEAR_CM:    sonar_cfg.near_threshold_cm = cfg_ch.data[9:0];
					REG_PAUSE:      sonar_cfg.pause_ticks = cfg_ch.data;
					default: ;
				endcase
			end
			if (echo_ch.valid && echo_ch.ready) begin
				sequence_tick(echo_ch.echo_level, calc);
				owed_pins.push_back(stim_typed ? stim_want : calc);
			end
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.trigger_level, res_ch.led_on, res_ch.distance_cm,
					res_ch.distance_ready, res_ch.no_echo};
				if (owed_pins.size() == 0) begin
					$error("pin result arrived with no tick outstanding");
					fails++;
				end else begin
					want = owed_pins.pop_front();
					if (got.trigger_level !== want.trigger_level) begin
						$error("trigger_level expected %0d got %0d",
							want.trigger_level, got.trigger_level);
						fails++;
					end
					if (got.led_on !== want.led_on) begin
						$error("led_on expected %0d got %0d", want.led_on, got.led_on);
						fails++;
					end
					if (got.distance_cm !== want.distance_cm) begin
						$error("distance_cm expected %0d got %0d",
							want.distance_cm, got.distance_cm);
						fails++;
					end
					if (got.distance_ready !== want.distance_ready) begin
						$error("distance_ready expected %0d got %0d",
							want.distance_ready, got.distance_ready);
						fails++;
					end
					if (got.no_echo !== want.no_echo) begin
						$error("no_echo expected %0d got %0d", want.no_echo, got.no_echo);
						fails++;
					end
				end
			end
		end
	end

	// Result sink: ready in runs, mostly short stalls with a few long ones
	initial begin : pace_sink
		int n;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm || $urandom_range(0, 99) < 70) begin
				res_ch.ready <= 1'b1;
				n = $urandom_range(1, 8);
			end else begin
				res_ch.ready <= 1'b0;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
					$urandom_range(1, 3);
			end
			repeat (n - 1) @(negedge clk);
		end
	end

	// Hold off the next request for a random gap, now and then until drained
	task automatic sender_gap();
		int n;
		if (!calm && $urandom_range(0, 3) == 0) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 3);
			echo_ch.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		if ($urandom_range(0, 199) == 0) begin
			echo_ch.valid <= 1'b0;
			do @(negedge clk); while (owed_pins.size() != 0);
		end
	endtask

	// Offer one tick and hold it until taken
	task automatic push_tick(input logic lvl, input logic typed, input urs_result_t want);
		echo_ch.valid <= 1'b1;
		echo_ch.echo_level <= lvl;
		stim_typed <= typed;
		stim_want <= want;
		do @(posedge clk); while (!echo_ch.ready);
		@(negedge clk);
	endtask

	// Stop offering ticks and wait until every owed result is back
	task automatic drain_pins();
		echo_ch.valid <= 1'b0;
		do @(negedge clk); while (owed_pins.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	// Reprogram all registers while idle, then run a stretch of shaped ticks
	task automatic run_setting(input logic [19:0] tl, input logic [19:0] th,
			input logic [19:0] lim, input logic [19:0] emax, input logic [19:0] tpc,
			input logic [19:0] near, input logic [19:0] pse, input int items,
			input bit long_mode);
		drain_pins();
		write_reg(REG_TRIG_LOW, tl);
		write_reg(REG_TRIG_HIGH, th);
		write_reg(REG_WAIT_LIMIT, lim);
		write_reg(REG_ECHO_MAX, emax);
		write_reg(REG_TICKS_CM, tpc);
		write_reg(REG_NEAR_CM, near);
		write_reg(REG_PAUSE, pse);
		write_reg(REG_SPARE, 20'($urandom));
		cfg_ch.valid <= 1'b0;
		long_echo = long_mode;
		calm = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < items; k++) begin
			sender_gap();
			push_tick(choose_echo(), 1'b0, IDLE_PINS);
		end
	endtask

	initial begin : run_stimulus
		arst_n = 1'b0;
		echo_ch.valid = 1'b0;
		echo_ch.echo_level = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		stim_typed = 1'b0;
		stim_want = IDLE_PINS;
		sonar_cfg = CFG_RESET;
		sonar = '0;
		sonar.phase = PH_TRIG_LOW;
		rise_delay = 0;
		echo_span = 0;
		silent_echo = 1'b0;
		long_echo = 1'b0;
		calm = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First measurement under reset settings, pins known by hand
		foreach (bringup_rows[r]) begin
			for (int k = 0; k < int'(bringup_rows[r].reps); k++) begin
				sender_gap();
				push_tick(bringup_rows[r].lvl, bringup_rows[r].typed, bringup_rows[r].want);
			end
		end

		// Longest limits; one cm per tick to saturate the distance
		run_setting(20'd1, 20'd1, 20'd1048575, 20'd65535, 20'd1, 20'd999, 20'd0,
			1060, 1'b1);
		// Short everything
		run_setting(20'd1, 20'd1, 20'd20, 20'd100, 20'd3, 20'd8, 20'd5, 50, 1'b0);
		// Zero lengths, zero wait limit, zero cap, zero pause
		run_setting(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 40, 1'b0);
		// Coarsest centimetre
		run_setting(20'd3, 20'd2, 20'd50, 20'd2000, 20'd255, 20'd3, 20'd10, 60, 1'b0);
		// Longest pause: enter it and stay there
		run_setting(20'd1, 20'd1, 20'd10, 20'd30, 20'd2, 20'd5, 20'd1048575, 30, 1'b0);
		// Random settings, upper data bits set above the register widths
		repeat (4) begin
			run_setting({12'($urandom), 8'($urandom_range(0, 6))},
				{12'($urandom), 8'($urandom_range(0, 6))},
				20'($urandom_range(0, 60)),
				{4'($urandom), 16'($urandom_range(0, 300))},
				{12'($urandom), 8'($urandom_range(0, 12))},
				($urandom_range(0, 1) == 0) ? {10'($urandom), 10'($urandom)} :
					20'($urandom_range(0, 40)),
				20'($urandom_range(0, 20)),
				20, 1'b0);
		end

		drain_pins();
		if (fails == 0)
			$display("ultrasonic_range_sequencer_tb passed");
		else
			$display("ultrasonic_range_sequencer_tb failed");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin : watchdog
		#20000000;
		$display("ultrasonic_range_sequencer_tb failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/urs_pkg.sv
rtl/core/urs_if.sv
rtl/core/urs_step.sv
rtl/core/ultrasonic_range_sequencer.sv
tb/ultrasonic_range_sequencer_tb.sv
